@@ hdl/length_prefixed_frame_deframer_defines.svh @@
// assertion macros shared by the checker
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// condition must never be seen while out of reset
`define LPFD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lpfd: forbidden condition seen");

// signal must hold on the cycle after a stall
`define LPFD_ASSERT_HOLD(label, clk, rst, stall, sig) \
   label: assert property (@(posedge clk) disable iff (rst) (stall) |=> $stable(sig)) \
      else $error("lpfd: value changed while stalled");

`endif

@@ hdl/lpfd_pkg.sv @@
package lpfd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_VALUE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_TOTAL    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TOTAL    = 2'd2;

   localparam logic [7:0]  HEADER_RESET    = 8'd170;
   localparam logic [15:0] MIN_TOTAL_RESET = 16'd5;
   localparam logic [15:0] MAX_TOTAL_RESET = 16'd512;
   localparam logic [15:0] PREFIX_BYTES    = 16'd3;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY
   } phase_type;

   // one queue entry: either the three prefix bytes or one body byte
   typedef struct packed {
      logic       three;
      logic       last;
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
   } entry_type;

endpackage

@@ hdl/length_prefixed_frame_deframer.sv @@
// Length-prefixed frame deframer. Received bytes enter on req_ one per transfer; the block
// hunts for the header byte, takes a 16-bit little-endian length, and forwards frames whose
// total (length + 3, wrapping at 16 bits) lies within the min/max registers. Frame bytes leave
// on rsp_ with tuser marking the header byte and tlast the byte that completes the total;
// rejected headers and hunted bytes produce nothing. One byte is accepted per cycle and one
// frame byte leaves per cycle while rsp_tready is high; the header, low and high length bytes
// are released together when the high length byte arrives, so that one input yields three
// output bytes, and a four-entry queue between the parser and the output stage absorbs the
// difference. req_tready drops only while that queue is full. Output throughput is bounded by
// the single output register, one transfer per cycle. A frame byte is written into the queue
// and then into the output register before it is presented on rsp_. Registers are written
// through csr_ (0 header value, 1 minimum total, 2 maximum total); the user must write them
// only while the block is idle, and the block itself does not enforce this.
module length_prefixed_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // frame_byte
   output logic                              rsp_tuser,   // frame_start
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [lpfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                q_full;
   logic                q_push;
   lpfd_pkg::entry_type q_entry;
   logic                q_pop;
   logic                q_head_valid;
   lpfd_pkg::entry_type q_head;

   lpfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   lpfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   lpfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ hdl/lpfd_front.sv @@
module lpfd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // rx_byte
   input  logic                              csr_we,
   input  logic [lpfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpfd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              q_full,
   output logic                              q_push,
   output lpfd_pkg::entry_type               q_entry
);

   lpfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  header_ff;
   logic [15:0] min_total_ff;
   logic [15:0] max_total_ff;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [15:0] rcvd_ff, rcvd_in;
   logic [15:0] total_ff, total_in;

   logic        accept;
   logic [15:0] total;
   logic        in_range;
   logic        tiny;
   logic [15:0] rcvd_plus;
   logic        body_done;
   logic        hdr_match;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // frame total wraps at 16 bits
   assign total     = {req_tdata, len_lo_ff} + lpfd_pkg::PREFIX_BYTES;
   assign in_range  = (total >= min_total_ff) && (total <= max_total_ff);
   assign tiny      = (total <= lpfd_pkg::PREFIX_BYTES);
   assign rcvd_plus = rcvd_ff + 16'd1;
   assign body_done = (rcvd_plus >= total_ff);
   assign hdr_match = (req_tdata == header_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= lpfd_pkg::HEADER_RESET;
         min_total_ff <= lpfd_pkg::MIN_TOTAL_RESET;
         max_total_ff <= lpfd_pkg::MAX_TOTAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lpfd_pkg::CSR_HEADER_VALUE: header_ff    <= csr_wdata[7:0];
            lpfd_pkg::CSR_MIN_TOTAL:    min_total_ff <= csr_wdata;
            lpfd_pkg::CSR_MAX_TOTAL:    max_total_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            lpfd_pkg::PH_HUNT:   if (hdr_match) phase_in = lpfd_pkg::PH_LEN_LO;
            lpfd_pkg::PH_LEN_LO: phase_in = lpfd_pkg::PH_LEN_HI;
            lpfd_pkg::PH_LEN_HI: begin
               if (!in_range || tiny) phase_in = lpfd_pkg::PH_HUNT;
               else phase_in = lpfd_pkg::PH_BODY;
            end
            lpfd_pkg::PH_BODY:   if (body_done) phase_in = lpfd_pkg::PH_HUNT;
            default:             phase_in = lpfd_pkg::PH_HUNT;
         endcase
      end
   end

   always_comb begin
      q_push    = 1'b0;
      q_entry   = '0;
      len_lo_in = len_lo_ff;
      rcvd_in   = rcvd_ff;
      total_in  = total_ff;
      if (accept) begin
         unique case (phase_ff)
            lpfd_pkg::PH_HUNT: begin
               if (hdr_match) begin
                  rcvd_in  = 16'd1;
                  total_in = 16'd0;
               end
            end
            lpfd_pkg::PH_LEN_LO: begin
               len_lo_in = req_tdata;
               rcvd_in   = 16'd2;
            end
            lpfd_pkg::PH_LEN_HI: begin
               if (!in_range) begin
                  rcvd_in  = 16'd0;
                  total_in = 16'd0;
               end else begin
                  q_push        = 1'b1;
                  q_entry.three = 1'b1;
                  q_entry.last  = tiny;
                  q_entry.data0 = header_ff;
                  q_entry.data1 = len_lo_ff;
                  q_entry.data2 = req_tdata;
                  // a total of three or less closes the frame on the prefix
                  if (tiny) begin
                     rcvd_in  = 16'd0;
                     total_in = 16'd0;
                  end else begin
                     rcvd_in  = lpfd_pkg::PREFIX_BYTES;
                     total_in = total;
                  end
               end
            end
            lpfd_pkg::PH_BODY: begin
               q_push        = 1'b1;
               q_entry.data0 = req_tdata;
               q_entry.last  = body_done;
               if (body_done) begin
                  rcvd_in  = 16'd0;
                  total_in = 16'd0;
               end else begin
                  rcvd_in = rcvd_plus;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lpfd_pkg::PH_HUNT;
         len_lo_ff <= 8'd0;
         rcvd_ff   <= 16'd0;
         total_ff  <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         len_lo_ff <= len_lo_in;
         rcvd_ff   <= rcvd_in;
         total_ff  <= total_in;
      end
   end

endmodule

@@ hdl/lpfd_queue.sv @@
module lpfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lpfd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output lpfd_pkg::entry_type head_entry
);

   lpfd_pkg::entry_type mem_ff [lpfd_pkg::QUEUE_DEPTH];
   logic [lpfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lpfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lpfd_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push;
   logic do_pop;

   assign full       = (cnt_ff == lpfd_pkg::QUEUE_CNT_W'(lpfd_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lpfd_pkg::QUEUE_PTR_W'(lpfd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + lpfd_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lpfd_pkg::QUEUE_PTR_W'(lpfd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + lpfd_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + lpfd_pkg::QUEUE_CNT_W'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - lpfd_pkg::QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ hdl/lpfd_back.sv @@
module lpfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  lpfd_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // frame_byte
   output logic                rsp_tuser,   // frame_start
   output logic                rsp_tlast    // frame_last
);

   lpfd_pkg::entry_type cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] sel_ff, sel_in;
   logic       final_byte;
   logic       xfer;

   assign final_byte = !cur_ff.three || (sel_ff == 2'd2);
   assign xfer       = cur_valid_ff && rsp_tready;
   // load the next entry when empty or when the current one is finished
   assign pop        = head_valid && (!cur_valid_ff || (xfer && final_byte));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      sel_in       = sel_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         sel_in       = 2'd0;
      end else if (xfer) begin
         if (final_byte) cur_valid_in = 1'b0;
         else sel_in = sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head_entry;
   end

   always_comb begin
      case (sel_ff)
         2'd0:    rsp_tdata = cur_ff.data0;
         2'd1:    rsp_tdata = cur_ff.data1;
         default: rsp_tdata = cur_ff.data2;
      endcase
   end

   assign rsp_tvalid = cur_valid_ff;
   assign rsp_tuser  = cur_ff.three && (sel_ff == 2'd0);
   assign rsp_tlast  = cur_ff.last && final_byte;

endmodule

@@ hdl/lpfd_checker.sv @@
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   logic       stall;
   logic       xfer;
   logic [9:0] rsp_word;
   logic       prev_start_ff;

   assign stall    = rsp_tvalid && !rsp_tready;
   assign xfer     = rsp_tvalid && rsp_tready;
   assign rsp_word = {rsp_tlast, rsp_tuser, rsp_tdata};

   always_ff @(posedge clock) begin
      if (reset) prev_start_ff <= 1'b0;
      else if (xfer) prev_start_ff <= rsp_tuser;
   end

   `LPFD_ASSERT_HOLD(a_valid_hold, clock, reset, stall, rsp_tvalid)
   `LPFD_ASSERT_HOLD(a_word_hold, clock, reset, stall, rsp_word)
   // a frame is at least three bytes: start and last never share a transfer
   `LPFD_ASSERT_NEVER(a_start_not_last, clock, reset, xfer && rsp_tuser && rsp_tlast)
   // the low length byte follows the header and neither starts nor ends a frame
   `LPFD_ASSERT_NEVER(a_after_start, clock, reset,
                      xfer && prev_start_ff && (rsp_tuser || rsp_tlast))

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

@@ dv/testbench.sv @@
module testbench;

   localparam logic [lpfd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       last;
   } frame_byte_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = 8'h00;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [7:0]                       rsp_tdata;
   logic                             rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we = 1'b0;
   logic [lpfd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lpfd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // stimulus and expected frame bytes
   logic [7:0]     pending_bytes[$];
   frame_byte_type frame_bytes_due[$];

   // deframer shadow: configuration and parse state
   logic [7:0]          cfg_header = lpfd_pkg::HEADER_RESET;
   logic [15:0]         cfg_min    = lpfd_pkg::MIN_TOTAL_RESET;
   logic [15:0]         cfg_max    = lpfd_pkg::MAX_TOTAL_RESET;
   lpfd_pkg::phase_type parse_phase = lpfd_pkg::PH_HUNT;
   logic [7:0]          held_low    = 8'h00;
   logic [15:0]         byte_count  = 16'd0;
   logic [15:0]         frame_total = 16'd0;

   logic idle_on   = 1'b1;
   logic req_taken = 1'b0;
   int   req_gap   = 0;
   int   rsp_gap   = 0;
   int   fail_count  = 0;
   int   quiet_cycles = 0;

   length_prefixed_frame_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // advance the parse state by one received byte, queue the frame bytes it releases
   function automatic void deframe_byte(input logic [7:0] b);
      logic [15:0] total;
      logic        done;
      case (parse_phase)
         lpfd_pkg::PH_HUNT: begin
            if (b == cfg_header) begin
               parse_phase = lpfd_pkg::PH_LEN_LO;
               byte_count  = 16'd1;
               frame_total = 16'd0;
            end
         end
         lpfd_pkg::PH_LEN_LO: begin
            held_low    = b;
            byte_count  = 16'd2;
            parse_phase = lpfd_pkg::PH_LEN_HI;
         end
         lpfd_pkg::PH_LEN_HI: begin
            total = {b, held_low} + lpfd_pkg::PREFIX_BYTES;
            if (total < cfg_min || total > cfg_max) begin
               parse_phase = lpfd_pkg::PH_HUNT;
               byte_count  = 16'd0;
               frame_total = 16'd0;
            end else begin
               done = (total <= lpfd_pkg::PREFIX_BYTES);
               frame_bytes_due.push_back('{cfg_header, 1'b1, 1'b0});
               frame_bytes_due.push_back('{held_low, 1'b0, 1'b0});
               frame_bytes_due.push_back('{b, 1'b0, done});
               if (done) begin
                  parse_phase = lpfd_pkg::PH_HUNT;
                  byte_count  = 16'd0;
                  frame_total = 16'd0;
               end else begin
                  parse_phase = lpfd_pkg::PH_BODY;
                  byte_count  = lpfd_pkg::PREFIX_BYTES;
                  frame_total = total;
               end
            end
         end
         default: begin
            byte_count = byte_count + 16'd1;
            done = (byte_count >= frame_total);
            frame_bytes_due.push_back('{b, 1'b0, done});
            if (done) begin
               parse_phase = lpfd_pkg::PH_HUNT;
               byte_count  = 16'd0;
               frame_total = 16'd0;
            end
         end
      endcase
   endfunction

   // byte source
   always @(negedge clock) begin : req_driver
      logic       next_valid;
      logic [7:0] next_data;
      if (!reset && (!req_tvalid || req_taken)) begin
         next_valid = 1'b0;
         next_data  = req_tdata;
         if (req_gap != 0) begin
            req_gap--;
         end else if (pending_bytes.size() != 0) begin
            next_valid = 1'b1;
            next_data  = pending_bytes.pop_front();
            if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 10);
         end
         req_tvalid <= next_valid;
         req_tdata  <= next_data;
      end
      req_taken = 1'b0;
   end

   // frame byte sink with random back-pressure
   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 10);
      end
   end

   always @(posedge clock) begin : monitor
      frame_byte_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected frame byte: data %h start %b last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser !== want.start
                   || rsp_tlast !== want.last) begin
                  if (fail_count < 10)
                     $display("mismatch: want %h/%b/%b got %h/%b/%b",
                              want.data, want.start, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic apply_settings(input logic [7:0] hdr, input logic [15:0] lo_total,
                                 input logic [15:0] hi_total);
      logic [7:0] junk;
      junk = 8'($urandom);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= lpfd_pkg::CSR_HEADER_VALUE;
      csr_wdata <= {junk, hdr};
      @(negedge clock);
      csr_index <= lpfd_pkg::CSR_MIN_TOTAL;
      csr_wdata <= lo_total;
      @(negedge clock);
      csr_index <= lpfd_pkg::CSR_MAX_TOTAL;
      csr_wdata <= hi_total;
      @(negedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_header = hdr;
      cfg_min    = lo_total;
      cfg_max    = hi_total;
   endtask

   task automatic queue_frame(input logic [7:0] hdr, input logic [15:0] len,
                              input logic with_body);
      pending_bytes.push_back(hdr);
      pending_bytes.push_back(len[7:0]);
      pending_bytes.push_back(len[15:8]);
      if (with_body)
         repeat (len)
            pending_bytes.push_back(($urandom_range(0, 7) == 0) ? hdr : 8'($urandom));
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || frame_bytes_due.size() != 0);
   endtask

   // drain, then feed filler until the parser is back to hunting
   task automatic finish_phase();
      wait_drained();
      while (parse_phase != lpfd_pkg::PH_HUNT) begin
         case (parse_phase)
            lpfd_pkg::PH_LEN_LO: repeat (2) pending_bytes.push_back(8'h00);
            lpfd_pkg::PH_LEN_HI: pending_bytes.push_back(8'h00);
            default:   repeat (frame_total - byte_count) pending_bytes.push_back(8'h00);
         endcase
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed frames, some out-of-range lengths and line noise
   task automatic random_frames(input int item_goal);
      int          items;
      int          pick;
      logic [15:0] len;
      items = 0;
      while (items < item_goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            len = 16'($urandom_range(cfg_min - 3, cfg_max - 3));
            queue_frame(cfg_header, len, 1'b1);
            items += len + 3;
         end else if (pick == 7) begin
            queue_frame(cfg_header, 16'($urandom_range(0, cfg_min - 4)), 1'b0);
            items += 3;
         end else if (pick == 8) begin
            queue_frame(cfg_header, 16'($urandom_range(cfg_max - 2, cfg_max + 200)), 1'b0);
            items += 3;
         end else begin
            repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0]  hdr;
      logic [15:0] lo_total;
      logic [15:0] hi_total;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: minimum total, short totals, wrap to zero, just over max
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      queue_frame(lpfd_pkg::HEADER_RESET, 16'd2, 1'b1);
      queue_frame(lpfd_pkg::HEADER_RESET, 16'd1, 1'b0);
      queue_frame(lpfd_pkg::HEADER_RESET, 16'hFFFD, 1'b0);
      queue_frame(lpfd_pkg::HEADER_RESET, 16'h01FE, 1'b0);
      // header value inside a body is plain data
      pending_bytes.push_back(lpfd_pkg::HEADER_RESET);
      pending_bytes.push_back(8'h03);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(lpfd_pkg::HEADER_RESET);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h00);
      queue_frame(lpfd_pkg::HEADER_RESET, 16'd4, 1'b1);
      finish_phase();

      // smallest window: only a total of four passes
      apply_settings(8'h00, 16'd4, 16'd4);
      queue_frame(8'h00, 16'd1, 1'b1);
      queue_frame(8'h00, 16'd0, 1'b0);
      queue_frame(8'h00, 16'd2, 1'b0);
      random_frames(15);
      finish_phase();

      // widest window
      apply_settings(8'hFF, 16'd4, 16'hFFFF);
      queue_frame(8'hFF, 16'd1, 1'b1);
      queue_frame(8'hFF, 16'd0, 1'b0);
      queue_frame(8'hFF, 16'hFFFE, 1'b0);
      queue_frame(8'hFF, 16'd8, 1'b1);
      finish_phase();

      // minimum above maximum drops every header
      apply_settings(8'h5A, 16'd600, 16'd100);
      queue_frame(8'h5A, 16'd200, 1'b0);
      queue_frame(8'h5A, 16'd50, 1'b0);
      queue_frame(8'h5A, 16'd700, 1'b0);
      finish_phase();

      hdr = 8'($urandom);
      apply_settings(hdr, 16'hFFFF, 16'hFFFF);
      queue_frame(hdr, 16'hFFFB, 1'b0);
      queue_frame(hdr, 16'hFFFD, 1'b0);
      finish_phase();

      hdr      = 8'($urandom);
      lo_total = 16'($urandom_range(4, 12));
      hi_total = 16'($urandom_range(lo_total, 40));
      apply_settings(hdr, lo_total, hi_total);
      random_frames(20);
      finish_phase();

      // closing stretch at full rate
      idle_on  = 1'b0;
      hdr      = 8'($urandom);
      lo_total = 16'($urandom_range(4, 10));
      hi_total = 16'($urandom_range(lo_total, 30));
      apply_settings(hdr, lo_total, hi_total);
      random_frames(20);
      finish_phase();

      if (fail_count == 0 && frame_bytes_due.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
